[rtl/paged_dram_ports_with_shifter_core_macros.svh]
// Assertion shorthands for the RTL of this block.
`ifndef PAGED_DRAM_PORTS_WITH_SHIFTER_CORE_MACROS_SVH
`define PAGED_DRAM_PORTS_WITH_SHIFTER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PDSH_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PDSH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pdsh_pkg.sv]
package pdsh_pkg;

  localparam int PORT_COUNT = 4;
  localparam int PORT_IDX_W = $clog2(PORT_COUNT);
  localparam int MEM_ADDR_W = 21;
  localparam int BASE_W     = 24;
  localparam int OFFSET_W   = 16;
  localparam int CTRL_W     = 7;

  // Memory select codes.
  localparam logic [1:0] MEM_NONE = 2'd0;
  localparam logic [1:0] MEM_ROM  = 2'd1;
  localparam logic [1:0] MEM_WRAM = 2'd2;
  localparam logic [1:0] MEM_DRAM = 2'd3;

  // Bank map.
  localparam logic [7:0] BANK_ROM_LAST   = 8'h3f;
  localparam logic [7:0] BANK_DRAM_LAST  = 8'h43;
  localparam logic [7:0] BANK_WRAM_FIRST = 8'h68;
  localparam logic [7:0] BANK_WRAM_LAST  = 8'h7f;
  localparam logic [7:0] BANK_IO         = 8'hff;

  // Fixed addresses in the I/O bank.
  localparam logic [12:0] ADDR_ID_ZERO   = 13'h18c4;
  localparam logic [12:0] ADDR_REGION_A  = 13'h18c5;
  localparam logic [12:0] ADDR_REGION_B  = 13'h18c6;
  localparam logic [12:0] ADDR_RAM_SIZE  = 13'h18c7;
  localparam logic [12:0] ADDR_SH_BYTE0  = 13'h1ae0;
  localparam logic [12:0] ADDR_SH_BYTE1  = 13'h1ae1;
  localparam logic [12:0] ADDR_SH_BYTE2  = 13'h1ae2;
  localparam logic [12:0] ADDR_SH_BYTE3  = 13'h1ae3;
  localparam logic [12:0] ADDR_SH_SHIFT  = 13'h1ae4;
  localparam logic [12:0] ADDR_SH_ROTATE = 13'h1ae5;
  localparam logic [12:0] ADDR_VER_LO    = 13'h1afd;
  localparam logic [12:0] ADDR_VER_MID   = 13'h1afe;
  localparam logic [12:0] ADDR_VER_HI    = 13'h1aff;
  localparam logic [12:0] PORT_REG_MASK  = 13'h1f8f;
  localparam logic [12:0] PORT_REG_BASE  = 13'h1a00;

  // Constant read bytes.
  localparam logic [7:0] ID_AA       = 8'haa;
  localparam logic [7:0] ID_55       = 8'h55;
  localparam logic [7:0] VER_MID_VAL = 8'h10;
  localparam logic [7:0] VER_HI_VAL  = 8'h51;

  localparam logic [BASE_W-1:0] PAGE_HIGH = 24'hff0000;

  // Port register codes, taken from the low address nibble.
  localparam logic [3:0] PREG_DATA0    = 4'd0;
  localparam logic [3:0] PREG_DATA1    = 4'd1;
  localparam logic [3:0] PREG_BASE0    = 4'd2;
  localparam logic [3:0] PREG_BASE1    = 4'd3;
  localparam logic [3:0] PREG_BASE2    = 4'd4;
  localparam logic [3:0] PREG_OFF_LO   = 4'd5;
  localparam logic [3:0] PREG_OFF_HI   = 4'd6;
  localparam logic [3:0] PREG_ADJ_LO   = 4'd7;
  localparam logic [3:0] PREG_ADJ_HI   = 4'd8;
  localparam logic [3:0] PREG_CTRL     = 4'd9;
  localparam logic [3:0] PREG_BASE_ADD = 4'd10;

  // Port control bits.
  localparam int CTRL_STEP      = 0;
  localparam int CTRL_PAGED     = 1;
  localparam int CTRL_HIGH      = 3;
  localparam int CTRL_STEP_BASE = 4;
  localparam int CTRL_BADD_LSB  = 5;

  // Base-add trigger modes in control bits 6:5.
  localparam logic [1:0] BADD_OFF_LO = 2'd1;
  localparam logic [1:0] BADD_OFF_HI = 2'd2;
  localparam logic [1:0] BADD_REG    = 2'd3;

  // Shifter register codes, taken from the low address bits.
  localparam logic [2:0] SH_BYTE0  = 3'd0;
  localparam logic [2:0] SH_BYTE1  = 3'd1;
  localparam logic [2:0] SH_BYTE2  = 3'd2;
  localparam logic [2:0] SH_BYTE3  = 3'd3;
  localparam logic [2:0] SH_SHIFT  = 3'd4;
  localparam logic [2:0] SH_ROTATE = 3'd5;

  // Configuration register indexes.
  localparam logic CFG_REGION_JAPAN   = 1'b0;
  localparam logic CFG_WORK_RAM_UNITS = 1'b1;

  typedef struct packed {
    logic                  access;
    logic                  wr;
    logic [3:0]            reg_sel;
    logic [PORT_IDX_W-1:0] port;
    logic [7:0]            data;
  } port_req_t;

  typedef struct packed {
    logic       wr;
    logic [2:0] sel;
    logic [7:0] data;
  } shift_req_t;

endpackage

[rtl/pdsh_ports.sv]
module pdsh_ports (
  input  logic                                  clk,
  input  logic                                  rst,
  input  pdsh_pkg::port_req_t                   req,
  output logic [pdsh_pkg::MEM_ADDR_W-1:0]       access_addr,
  output logic [7:0]                            rdata
);

  logic [pdsh_pkg::CTRL_W-1:0]   ctrl   [pdsh_pkg::PORT_COUNT];
  logic [pdsh_pkg::BASE_W-1:0]   base   [pdsh_pkg::PORT_COUNT];
  logic [pdsh_pkg::OFFSET_W-1:0] offset [pdsh_pkg::PORT_COUNT];
  logic [pdsh_pkg::OFFSET_W-1:0] adjust [pdsh_pkg::PORT_COUNT];

  logic [pdsh_pkg::CTRL_W-1:0]   cur_ctrl;
  logic [pdsh_pkg::BASE_W-1:0]   cur_base;
  logic [pdsh_pkg::OFFSET_W-1:0] cur_off;
  logic [pdsh_pkg::OFFSET_W-1:0] cur_adj;
  logic [pdsh_pkg::OFFSET_W-1:0] off_wr;
  logic [pdsh_pkg::OFFSET_W-1:0] badd_off;
  logic [pdsh_pkg::BASE_W-1:0]   base_sum;
  logic [pdsh_pkg::BASE_W-1:0]   addr_full;
  logic [1:0]                    badd_need;

  // Offset plus the optional high page, as added into an address or the base.
  function automatic logic [pdsh_pkg::BASE_W-1:0] page_extra(
    input logic [pdsh_pkg::CTRL_W-1:0]   c,
    input logic [pdsh_pkg::OFFSET_W-1:0] o
  );
    logic [pdsh_pkg::BASE_W-1:0] e;
    e = {{(pdsh_pkg::BASE_W - pdsh_pkg::OFFSET_W){1'b0}}, o};
    if (c[pdsh_pkg::CTRL_HIGH]) begin
      e = e + pdsh_pkg::PAGE_HIGH;
    end
    return e;
  endfunction

  always_comb begin
    cur_ctrl = ctrl[req.port];
    cur_base = base[req.port];
    cur_off  = offset[req.port];
    cur_adj  = adjust[req.port];

    addr_full = cur_base;
    if (cur_ctrl[pdsh_pkg::CTRL_PAGED]) begin
      addr_full = cur_base + page_extra(cur_ctrl, cur_off);
    end
    access_addr = addr_full[pdsh_pkg::MEM_ADDR_W-1:0];

    if (req.reg_sel == pdsh_pkg::PREG_OFF_LO) begin
      off_wr = {cur_off[15:8], req.data};
    end else begin
      off_wr = {req.data, cur_off[7:0]};
    end

    // The offset-byte writes add the freshly written offset.
    if (req.reg_sel == pdsh_pkg::PREG_OFF_LO || req.reg_sel == pdsh_pkg::PREG_OFF_HI) begin
      badd_off = off_wr;
    end else begin
      badd_off = cur_off;
    end
    base_sum = cur_base + page_extra(cur_ctrl, badd_off);

    unique case (req.reg_sel)
      pdsh_pkg::PREG_OFF_LO: badd_need = pdsh_pkg::BADD_OFF_LO;
      pdsh_pkg::PREG_OFF_HI: badd_need = pdsh_pkg::BADD_OFF_HI;
      default:               badd_need = pdsh_pkg::BADD_REG;
    endcase

    unique case (req.reg_sel)
      pdsh_pkg::PREG_BASE0:  rdata = cur_base[7:0];
      pdsh_pkg::PREG_BASE1:  rdata = cur_base[15:8];
      pdsh_pkg::PREG_BASE2:  rdata = cur_base[23:16];
      pdsh_pkg::PREG_OFF_LO: rdata = cur_off[7:0];
      pdsh_pkg::PREG_OFF_HI: rdata = cur_off[15:8];
      pdsh_pkg::PREG_ADJ_LO: rdata = cur_adj[7:0];
      pdsh_pkg::PREG_ADJ_HI: rdata = cur_adj[15:8];
      pdsh_pkg::PREG_CTRL:   rdata = {1'b0, cur_ctrl};
      default:               rdata = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < pdsh_pkg::PORT_COUNT; i++) begin
        ctrl[i]   <= '0;
        base[i]   <= '0;
        offset[i] <= '0;
        adjust[i] <= '0;
      end
    end else if (req.access) begin
      if (cur_ctrl[pdsh_pkg::CTRL_STEP]) begin
        if (cur_ctrl[pdsh_pkg::CTRL_STEP_BASE]) begin
          base[req.port] <= cur_base + {8'h00, cur_adj};
        end else begin
          offset[req.port] <= cur_off + cur_adj;
        end
      end
    end else if (req.wr) begin
      unique case (req.reg_sel)
        pdsh_pkg::PREG_BASE0: base[req.port][7:0]   <= req.data;
        pdsh_pkg::PREG_BASE1: base[req.port][15:8]  <= req.data;
        pdsh_pkg::PREG_BASE2: base[req.port][23:16] <= req.data;
        pdsh_pkg::PREG_OFF_LO, pdsh_pkg::PREG_OFF_HI, pdsh_pkg::PREG_BASE_ADD: begin
          if (req.reg_sel != pdsh_pkg::PREG_BASE_ADD) begin
            offset[req.port] <= off_wr;
          end
          if (cur_ctrl[pdsh_pkg::CTRL_BADD_LSB +: 2] == badd_need) begin
            base[req.port] <= base_sum;
          end
        end
        pdsh_pkg::PREG_ADJ_LO: adjust[req.port][7:0]  <= req.data;
        pdsh_pkg::PREG_ADJ_HI: adjust[req.port][15:8] <= req.data;
        pdsh_pkg::PREG_CTRL:   ctrl[req.port]         <= req.data[6:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/pdsh_shifter.sv]
module pdsh_shifter (
  input  logic                  clk,
  input  logic                  rst,
  input  pdsh_pkg::shift_req_t  req,
  output logic [7:0]            rdata
);

  logic [31:0] value;
  logic [3:0]  shift_amt;
  logic [3:0]  rot_amt;
  logic [3:0]  amt;
  logic [4:0]  rot_n;
  logic [31:0] shifted;
  logic [31:0] rotated;

  always_comb begin
    amt = req.data[3:0];
    // Amounts with bit 3 set count down from 16.
    if (amt[3]) begin
      shifted = value >> (5'd16 - {1'b0, amt});
      rot_n   = 5'd16 - {1'b0, amt};
    end else begin
      shifted = value << amt;
      rot_n   = {1'b0, amt};
    end
    rotated = (value << rot_n) | (value >> (6'd32 - {1'b0, rot_n}));

    unique case (req.sel)
      pdsh_pkg::SH_BYTE0:  rdata = value[7:0];
      pdsh_pkg::SH_BYTE1:  rdata = value[15:8];
      pdsh_pkg::SH_BYTE2:  rdata = value[23:16];
      pdsh_pkg::SH_BYTE3:  rdata = value[31:24];
      pdsh_pkg::SH_SHIFT:  rdata = {4'h0, shift_amt};
      pdsh_pkg::SH_ROTATE: rdata = {4'h0, rot_amt};
      default:             rdata = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value     <= '0;
      shift_amt <= '0;
      rot_amt   <= '0;
    end else if (req.wr) begin
      unique case (req.sel)
        pdsh_pkg::SH_BYTE0: value[7:0]   <= req.data;
        pdsh_pkg::SH_BYTE1: value[15:8]  <= req.data;
        pdsh_pkg::SH_BYTE2: value[23:16] <= req.data;
        pdsh_pkg::SH_BYTE3: value[31:24] <= req.data;
        pdsh_pkg::SH_SHIFT: begin
          shift_amt <= amt;
          value     <= shifted;
        end
        pdsh_pkg::SH_ROTATE: begin
          rot_amt <= amt;
          value   <= rotated;
        end
        default: ;
      endcase
    end
  end

endmodule

[rtl/paged_dram_ports_with_shifter_core.sv]
// Pipeline: an accepted item is held in the input register and then moves on to the
// output register, from which its result is offered.
// Throughput: one item per cycle; the input register and the output register pass
// items on every cycle while the output side keeps taking results.
// Reset (rst, synchronous): clears all port and shifter state and the pipeline valid flags; the region
// flag resets to Japanese and the work RAM size to three 64 KiB units.
`include "paged_dram_ports_with_shifter_core_macros.svh"

module paged_dram_ports_with_shifter_core (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // bank [7:0], bank_address [20:8], bus_data [28:21]
  input  logic [0:0]  s_tuser,   // command [0]
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // read_byte [7:0], mem_address [28:8]
  output logic [2:0]  m_tuser,   // mem_select [1:0], mem_write [2]
  // Configuration writes.
  input  logic        cfg_wen,
  input  logic [0:0]  cfg_index,
  input  logic [5:0]  cfg_data
);

  // The input register holds one item. It moves on to the output register when
  // that register is empty or its item is being taken; the item's state updates
  // happen on that same edge, so the next item always sees them.
  logic        in_valid;
  logic        in_cmd;
  logic [7:0]  in_bank;
  logic [12:0] in_addr;
  logic [7:0]  in_data;
  logic        advance;

  logic        region_japan;
  logic [5:0]  work_ram_units;

  logic [7:0]                        out_rb;
  logic [1:0]                        out_sel;
  logic [pdsh_pkg::MEM_ADDR_W-1:0]   out_addr;
  logic                              out_write;

  logic [7:0]                        rb_next;
  logic [1:0]                        sel_next;
  logic [pdsh_pkg::MEM_ADDR_W-1:0]   maddr_next;

  pdsh_pkg::port_req_t               port_req;
  pdsh_pkg::shift_req_t              shift_req;
  logic                              dec_access;
  logic                              dec_port_wr;
  logic                              dec_shift_wr;
  logic [pdsh_pkg::MEM_ADDR_W-1:0]   port_addr;
  logic [7:0]                        port_rdata;
  logic [7:0]                        shift_rdata;
  logic [12:0]                       reg_addr;
  logic                              port_hit;
  logic [7:0]                        wram_bank;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd  <= s_tuser[0];
      in_bank <= s_tdata[7:0];
      in_addr <= s_tdata[20:8];
      in_data <= s_tdata[28:21];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      region_japan   <= 1'b1;
      work_ram_units <= 6'd3;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        pdsh_pkg::CFG_REGION_JAPAN:   region_japan   <= cfg_data[0];
        pdsh_pkg::CFG_WORK_RAM_UNITS: work_ram_units <= cfg_data;
        default: ;
      endcase
    end
  end

  // Address decode. The port register window repeats under the address mask, and
  // the port is picked by address bits 5:4 there, or by the bank in the DRAM banks.
  assign reg_addr  = in_addr & pdsh_pkg::PORT_REG_MASK;
  assign port_hit  = (reg_addr[12:4] == pdsh_pkg::PORT_REG_BASE[12:4]) &&
                     (reg_addr[3:0] <= pdsh_pkg::PREG_BASE_ADD);
  assign wram_bank = in_bank - pdsh_pkg::BANK_WRAM_FIRST;

  always_comb begin
    rb_next      = in_cmd ? 8'h00 : in_data;
    sel_next     = pdsh_pkg::MEM_NONE;
    maddr_next   = '0;
    dec_access   = 1'b0;
    dec_port_wr  = 1'b0;
    dec_shift_wr = 1'b0;

    priority if (in_bank <= pdsh_pkg::BANK_ROM_LAST) begin
      // ROM is read only; writes go nowhere.
      if (!in_cmd) begin
        sel_next   = pdsh_pkg::MEM_ROM;
        maddr_next = {2'b00, in_bank[5:0], in_addr};
        rb_next    = 8'h00;
      end
    end else if (in_bank <= pdsh_pkg::BANK_DRAM_LAST) begin
      sel_next   = pdsh_pkg::MEM_DRAM;
      maddr_next = port_addr;
      rb_next    = 8'h00;
      dec_access = 1'b1;
    end else if (in_bank >= pdsh_pkg::BANK_WRAM_FIRST && in_bank <= pdsh_pkg::BANK_WRAM_LAST) begin
      sel_next   = pdsh_pkg::MEM_WRAM;
      maddr_next = {3'b000, wram_bank[4:0], in_addr};
      rb_next    = 8'h00;
    end else if (in_bank == pdsh_pkg::BANK_IO && !in_cmd) begin
      unique case (in_addr)
        pdsh_pkg::ADDR_ID_ZERO:  rb_next = 8'h00;
        pdsh_pkg::ADDR_REGION_A: rb_next = region_japan ? pdsh_pkg::ID_AA : pdsh_pkg::ID_55;
        pdsh_pkg::ADDR_REGION_B: rb_next = region_japan ? pdsh_pkg::ID_55 : pdsh_pkg::ID_AA;
        pdsh_pkg::ADDR_RAM_SIZE: rb_next = {2'b00, work_ram_units};
        pdsh_pkg::ADDR_SH_BYTE0, pdsh_pkg::ADDR_SH_BYTE1, pdsh_pkg::ADDR_SH_BYTE2,
        pdsh_pkg::ADDR_SH_BYTE3, pdsh_pkg::ADDR_SH_SHIFT, pdsh_pkg::ADDR_SH_ROTATE:
          rb_next = shift_rdata;
        pdsh_pkg::ADDR_VER_LO:   rb_next = 8'h00;
        pdsh_pkg::ADDR_VER_MID:  rb_next = pdsh_pkg::VER_MID_VAL;
        pdsh_pkg::ADDR_VER_HI:   rb_next = pdsh_pkg::VER_HI_VAL;
        default: begin
          if (port_hit) begin
            if (reg_addr[3:0] == pdsh_pkg::PREG_DATA0 || reg_addr[3:0] == pdsh_pkg::PREG_DATA1) begin
              sel_next   = pdsh_pkg::MEM_DRAM;
              maddr_next = port_addr;
              rb_next    = 8'h00;
              dec_access = 1'b1;
            end else if (reg_addr[3:0] != pdsh_pkg::PREG_BASE_ADD) begin
              rb_next = port_rdata;
            end
          end
        end
      endcase
    end else if (in_bank == pdsh_pkg::BANK_IO) begin
      unique case (in_addr)
        pdsh_pkg::ADDR_SH_BYTE0, pdsh_pkg::ADDR_SH_BYTE1, pdsh_pkg::ADDR_SH_BYTE2,
        pdsh_pkg::ADDR_SH_BYTE3, pdsh_pkg::ADDR_SH_SHIFT, pdsh_pkg::ADDR_SH_ROTATE:
          dec_shift_wr = 1'b1;
        default: begin
          if (port_hit) begin
            if (reg_addr[3:0] == pdsh_pkg::PREG_DATA0 || reg_addr[3:0] == pdsh_pkg::PREG_DATA1) begin
              sel_next   = pdsh_pkg::MEM_DRAM;
              maddr_next = port_addr;
              dec_access = 1'b1;
            end else begin
              dec_port_wr = 1'b1;
            end
          end
        end
      endcase
    end else begin
      // Unmapped banks select nothing; a read hands back the bus byte.
    end
  end

  // Requests to the register files; state changes only on the edge the item moves on.
  always_comb begin
    port_req.access  = dec_access && advance;
    port_req.wr      = dec_port_wr && advance;
    port_req.reg_sel = reg_addr[3:0];
    port_req.port    = (in_bank == pdsh_pkg::BANK_IO) ? in_addr[4 +: pdsh_pkg::PORT_IDX_W]
                                                      : in_bank[pdsh_pkg::PORT_IDX_W-1:0];
    port_req.data    = in_data;

    shift_req.wr     = dec_shift_wr && advance;
    shift_req.sel    = in_addr[2:0];
    shift_req.data   = in_data;
  end

  pdsh_ports u_ports (
    .clk         (clk),
    .rst         (rst),
    .req         (port_req),
    .access_addr (port_addr),
    .rdata       (port_rdata)
  );

  pdsh_shifter u_shifter (
    .clk   (clk),
    .rst   (rst),
    .req   (shift_req),
    .rdata (shift_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rb    <= rb_next;
      out_sel   <= sel_next;
      out_addr  <= maddr_next;
      out_write <= in_cmd && (sel_next != pdsh_pkg::MEM_NONE);
    end
  end

  assign m_tdata = {3'b000, out_addr, out_rb};
  assign m_tuser = {out_write, out_sel};

  `PDSH_ASSERT_SAME(a_empty_stage_ready, !in_valid, s_tready, "input stage empty but not ready")
  `PDSH_ASSERT_NEXT(a_stalled_item_holds, in_valid && !advance, in_valid && $stable(in_addr) && $stable(in_bank) && $stable(in_cmd), "stalled item changed")
  `PDSH_ASSERT_NEXT(a_advance_gives_result, advance, m_tvalid, "moved item did not reach the output")
  `PDSH_ASSERT_SAME(a_no_memory_no_strobe, m_tvalid && out_sel == pdsh_pkg::MEM_NONE, !out_write && out_addr == '0, "strobe or address without a memory")

endmodule
